// File: sv/olad_pkg.sv
// Shared types and constants for the ordered list block.
package olad_pkg;

    localparam int DEPTH = 16;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int VAL_W = 32;

    typedef enum logic [1:0] {
        MODE_APPEND  = 2'd0,
        MODE_DELETE  = 2'd1,
        MODE_DISPLAY = 2'd2,
        MODE_NONE    = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_INS_FIRST = 3'd0,
        ST_INSERTED  = 3'd1,
        ST_DELETED   = 3'd2,
        ST_NOTFOUND  = 3'd3,
        ST_EMPTY     = 3'd4,
        ST_FULL      = 3'd5,
        ST_ENTRY     = 3'd6,
        ST_RSVD      = 3'd7
    } status_t;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_APPEND,
        OP_DELETE,
        OP_ROTATE
    } cell_op_t;

    typedef enum logic {
        S_IDLE,
        S_DISPLAY
    } state_t;

    // Command broadcast to every cell
    typedef struct packed {
        cell_op_t                 op;
        logic signed [VAL_W-1:0]  operand;
    } cell_ctl_t;

    // Position flags for one cell
    typedef struct packed {
        logic valid;     // cell lies below the fill count
        logic app_slot;  // cell is the first free slot
        logic rot_tail;  // cell holds the tail entry
    } cell_sel_t;

endpackage

// File: sv/olad_in_if.sv
// Command channel: mode and operand value.
interface olad_in_if;
    logic                              valid;
    logic                              ready;
    logic [1:0]                        mode;
    logic signed [olad_pkg::VAL_W-1:0] value;

    modport source (output valid, output mode, output value, input ready);
    modport sink   (input valid, input mode, input value, output ready);
endinterface

// File: sv/olad_out_if.sv
// Response channel: status, entry value and last marker.
interface olad_out_if;
    logic                              valid;
    logic                              ready;
    olad_pkg::status_t                 status;
    logic signed [olad_pkg::VAL_W-1:0] entry_value;
    logic                              last;

    modport source (output valid, output status, output entry_value, output last, input ready);
    modport sink   (input valid, input status, input entry_value, input last, output ready);
endinterface

// File: sv/ordered_list_append_delete.sv
// Append and delete give their one result in the register in the cycle after acceptance.
// Throughput: one append or delete per cycle while rsp is free, from the compare-and-shift row.
// Display: N results for N entries, one per cycle while each is taken, by rotating the row
// past the head cell. No new command is taken during a display run.
// Reset: rst_n asynchronous, active low; clears the fill count, the sequencer and the
// response valid. Entry cells are not reset; no clearing pass is needed.
module ordered_list_append_delete (
    input  logic              clk,
    input  logic              rst_n,
    olad_in_if.sink           cmd,
    olad_out_if.source        rsp
);

    localparam int DEPTH = olad_pkg::DEPTH;
    localparam int CNT_W = olad_pkg::CNT_W;
    localparam int VAL_W = olad_pkg::VAL_W;

    olad_pkg::state_t                state_reg;
    olad_pkg::state_t                state_next;
    logic [CNT_W-1:0]                count_reg;
    logic [CNT_W-1:0]                count_next;
    logic [CNT_W-1:0]                rem_reg;
    logic [CNT_W-1:0]                rem_next;
    logic                            out_valid_reg;
    logic                            out_valid_next;
    olad_pkg::status_t               status_reg;
    olad_pkg::status_t               status_next;
    logic signed [VAL_W-1:0]         value_reg;
    logic signed [VAL_W-1:0]         value_next;
    logic                            last_reg;
    logic                            last_next;

    logic                            slot_free;
    logic                            accept;
    logic                            load_out;
    logic                            found;
    olad_pkg::cell_ctl_t             ctl;
    olad_pkg::cell_sel_t             sel [DEPTH];
    logic signed [VAL_W-1:0]         cell_value [DEPTH];
    logic                            match [DEPTH+1];

    assign slot_free = !out_valid_reg || rsp.ready;
    assign accept    = cmd.valid && cmd.ready;

    // Cell row
    assign match[0] = 1'b0;
    assign found    = match[DEPTH];

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic signed [VAL_W-1:0] right_value;

        if (i == DEPTH - 1)
        begin : g_end
            assign right_value = cell_value[i];
        end
        else
        begin : g_mid
            assign right_value = cell_value[i+1];
        end

        assign sel[i].valid    = CNT_W'(i) < count_reg;
        assign sel[i].app_slot = CNT_W'(i) == count_reg;
        assign sel[i].rot_tail = CNT_W'(i + 1) == count_reg;

        olad_cell u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .sel        (sel[i]),
            .next_value (right_value),
            .head_value (cell_value[0]),
            .match_in   (match[i]),
            .value      (cell_value[i]),
            .match_out  (match[i+1])
        );
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            olad_pkg::S_IDLE:
            begin
                if (accept && olad_pkg::mode_t'(cmd.mode) == olad_pkg::MODE_DISPLAY
                    && count_reg != '0)
                begin
                    state_next = olad_pkg::S_DISPLAY;
                end
            end
            olad_pkg::S_DISPLAY:
            begin
                if (slot_free && rem_reg == CNT_W'(1))
                begin
                    state_next = olad_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = olad_pkg::S_IDLE;
            end
        endcase
    end

    // Outputs, cell command and counters
    always_comb
    begin
        cmd.ready   = 1'b0;
        ctl.op      = olad_pkg::OP_HOLD;
        ctl.operand = cmd.value;
        load_out    = 1'b0;
        status_next = status_reg;
        value_next  = value_reg;
        last_next   = last_reg;
        count_next  = count_reg;
        rem_next    = rem_reg;
        unique case (state_reg)
            olad_pkg::S_IDLE:
            begin
                cmd.ready = slot_free;
                if (accept)
                begin
                    value_next = cmd.value;
                    last_next  = 1'b1;
                    unique case (olad_pkg::mode_t'(cmd.mode))
                        olad_pkg::MODE_APPEND:
                        begin
                            load_out = 1'b1;
                            if (count_reg == CNT_W'(DEPTH))
                            begin
                                status_next = olad_pkg::ST_FULL;
                            end
                            else
                            begin
                                ctl.op      = olad_pkg::OP_APPEND;
                                status_next = (count_reg == '0) ? olad_pkg::ST_INS_FIRST
                                                                : olad_pkg::ST_INSERTED;
                                count_next  = count_reg + CNT_W'(1);
                            end
                        end
                        olad_pkg::MODE_DELETE:
                        begin
                            load_out = 1'b1;
                            if (count_reg == '0)
                            begin
                                status_next = olad_pkg::ST_EMPTY;
                            end
                            else if (found)
                            begin
                                ctl.op      = olad_pkg::OP_DELETE;
                                status_next = olad_pkg::ST_DELETED;
                                count_next  = count_reg - CNT_W'(1);
                            end
                            else
                            begin
                                status_next = olad_pkg::ST_NOTFOUND;
                            end
                        end
                        olad_pkg::MODE_DISPLAY:
                        begin
                            if (count_reg == '0)
                            begin
                                load_out    = 1'b1;
                                status_next = olad_pkg::ST_EMPTY;
                                value_next  = '0;
                            end
                            else
                            begin
                                rem_next = count_reg;
                            end
                        end
                        olad_pkg::MODE_NONE:
                        begin
                            load_out = 1'b0;
                        end
                        default:
                        begin
                            load_out = 1'b0;
                        end
                    endcase
                end
            end
            olad_pkg::S_DISPLAY:
            begin
                // emit the head entry and rotate the row by one
                if (slot_free)
                begin
                    ctl.op      = olad_pkg::OP_ROTATE;
                    load_out    = 1'b1;
                    status_next = olad_pkg::ST_ENTRY;
                    value_next  = cell_value[0];
                    last_next   = (rem_reg == CNT_W'(1));
                    rem_next    = rem_reg - CNT_W'(1);
                end
            end
            default:
            begin
                cmd.ready = 1'b0;
            end
        endcase
    end

    // Response valid: set on load, drop when taken
    always_comb
    begin
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= olad_pkg::S_IDLE;
            count_reg     <= '0;
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rem_reg       <= rem_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the response payload
    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        value_reg  <= value_next;
        last_reg   <= last_next;
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = status_reg;
    assign rsp.entry_value = value_reg;
    assign rsp.last        = last_reg;

endmodule

// File: sv/olad_cell.sv
// One list cell: holds an entry, compares it, and takes from its right neighbor, the operand or the head.
module olad_cell (
    input  logic                              clk,
    input  olad_pkg::cell_ctl_t               ctl,
    input  olad_pkg::cell_sel_t               sel,
    input  logic signed [olad_pkg::VAL_W-1:0] next_value,
    input  logic signed [olad_pkg::VAL_W-1:0] head_value,
    input  logic                              match_in,
    output logic signed [olad_pkg::VAL_W-1:0] value,
    output logic                              match_out
);

    logic signed [olad_pkg::VAL_W-1:0] value_reg;
    logic signed [olad_pkg::VAL_W-1:0] value_next;
    logic                              hit;

    // Ripple the first-match flag toward the tail
    always_comb
    begin
        hit       = sel.valid && (value_reg == ctl.operand);
        match_out = match_in | hit;
    end

    // Select the next entry value
    always_comb
    begin
        value_next = value_reg;
        unique case (ctl.op)
            olad_pkg::OP_HOLD:
            begin
                value_next = value_reg;
            end
            olad_pkg::OP_APPEND:
            begin
                if (sel.app_slot)
                begin
                    value_next = ctl.operand;
                end
            end
            olad_pkg::OP_DELETE:
            begin
                // close the gap at and after the first match
                if (match_out)
                begin
                    value_next = next_value;
                end
            end
            olad_pkg::OP_ROTATE:
            begin
                value_next = sel.rot_tail ? head_value : next_value;
            end
            default:
            begin
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

// File: sv/olad_checker.sv
// Port-level checks for the ordered list block, bound to the top level.
module olad_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cmd_valid,
    input  logic                              cmd_ready,
    input  logic [1:0]                        cmd_mode,
    input  logic                              rsp_valid,
    input  logic                              rsp_ready,
    input  olad_pkg::status_t                 rsp_status,
    input  logic                              rsp_last
);

    // Hold a stalled response
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped while stalled");

    // Every real command gives a response; a display run starts from the display state, after the others
    a_cmd_resp: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready && cmd_mode != olad_pkg::MODE_NONE |=> ##[0:1] rsp_valid)
        else $error("command produced no response");

    // Single-result commands close their transaction at once
    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready && (cmd_mode == olad_pkg::MODE_APPEND
                                   || cmd_mode == olad_pkg::MODE_DELETE)
        |=> rsp_last && rsp_status != olad_pkg::ST_ENTRY)
        else $error("append or delete response malformed");

    // Anything but a listed entry ends its transaction
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status != olad_pkg::ST_ENTRY |-> rsp_last
                                     && rsp_status != olad_pkg::ST_RSVD)
        else $error("non-entry response without last");

endmodule

bind ordered_list_append_delete olad_checker u_olad_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd.valid),
    .cmd_ready  (cmd.ready),
    .cmd_mode   (cmd.mode),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_status (rsp.status),
    .rsp_last   (rsp.last)
);
